// ===== sv/swdtm_pkg.sv =====
package swdtm_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_XFER  = 2'd1;
  localparam logic [1:0] FUNC_LRST  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAULT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_PARITY  = 2'd3;

  localparam logic [2:0] ACK_OK     = 3'b001;
  localparam logic [2:0] ACK_WAIT   = 3'b010;
  localparam logic [2:0] ACK_FAULT  = 3'b100;

  localparam logic [7:0] CFG_RESET_HIGH_LEN = 8'd0;
  localparam logic [7:0] CFG_IDLE_LOW_LEN   = 8'd1;

  localparam logic [7:0] RESET_HIGH_LEN_DEF = 8'd100;
  localparam logic [7:0] IDLE_LOW_LEN_DEF   = 8'd20;

  localparam logic [15:0] SWITCH_SEQ = 16'hE79E;
  localparam logic [7:0]  SEQ_BITS   = 8'd16;
  localparam logic [7:0]  HDR_BITS   = 8'd8;
  localparam logic [7:0]  ACK_BITS   = 8'd3;
  localparam logic [7:0]  DATA_BITS  = 8'd32;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_LR_HI1  = 4'd1,
    PH_LR_SEQ  = 4'd2,
    PH_LR_HI2  = 4'd3,
    PH_LR_LOW  = 4'd4,
    PH_HDR     = 4'd5,
    PH_TRN_A   = 4'd6,
    PH_ACK     = 4'd7,
    PH_ACK_TRN = 4'd8,
    PH_TRN_W   = 4'd9,
    PH_WDATA   = 4'd10,
    PH_RDATA   = 4'd11,
    PH_RTRN    = 4'd12,
    PH_RIDLE   = 4'd13
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        swdio_in;
    logic        read_not_write;
    logic        ap_not_dp;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic        swclk_pulse;
    logic        swdio_oe;
    logic        swdio_out;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [2:0]  ack_code;
    logic [31:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [7:0] data;
  } cfg_wr_t;

  // request: {A[3:2], RnW, APnDP}
  function automatic logic hdr_bit(input logic [3:0] req, input logic [2:0] pos);
    logic b;
    case (pos)
      3'd0:    b = 1'b1;
      3'd5:    b = ^req;
      3'd6:    b = 1'b0;
      3'd7:    b = 1'b1;
      default: b = req[pos[1:0] - 2'd1];
    endcase
    return b;
  endfunction

endpackage

// ===== sv/swdtm_if.sv =====
interface swdtm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        swdio_in;
  logic        read_not_write;
  logic        ap_not_dp;
  logic [1:0]  reg_addr;
  logic [31:0] write_data;

  modport source (output valid, func, swdio_in, read_not_write, ap_not_dp, reg_addr,
                  write_data, input ready);
  modport sink (input valid, func, swdio_in, read_not_write, ap_not_dp, reg_addr,
                write_data, output ready);
endinterface

interface swdtm_out_if;
  logic        valid;
  logic        ready;
  logic        swclk_pulse;
  logic        swdio_oe;
  logic        swdio_out;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [2:0]  ack_code;
  logic [31:0] read_data;

  modport source (output valid, swclk_pulse, swdio_oe, swdio_out, busy_res, done_res,
                  status, ack_code, read_data, input ready);
  modport sink (input valid, swclk_pulse, swdio_oe, swdio_out, busy_res, done_res,
                status, ack_code, read_data, output ready);
endinterface

interface swdtm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== sv/swd_transaction_master_unit.sv =====
// Serial Wire Debug host bit engine. A start item (func 1) latches one DP/AP read or write,
// func 2 begins a line reset; each tick item (func 0) is one SWCLK period and returns one
// result with the pulse, drive enable and level for that period, plus busy, done, status,
// the last ack and, on the closing tick of a good read, the data word. Every input item
// yields exactly one result. Throughput is one item per clock while the output is not
// stalled: an input register feeds the state update and result logic, which loads an
// output register, and both sides may stall freely. Starts while busy and func 3 produce
// a result but change nothing. Configuration: register 0 sets the high run length of a
// line reset, register 1 the trailing idle-low length; write them only while idle.
module swd_transaction_master_unit (
  input  logic         clk,
  input  logic         rst_n,
  swdtm_in_if.sink     in_ch,
  swdtm_out_if.source  out_ch,
  swdtm_cfg_if.sink    cfg_ch
);
  import swdtm_pkg::*;

  in_item_t  in_item, eng_item;
  out_item_t eng_res, out_item;
  cfg_wr_t   cfg_wr;
  logic      eng_valid, step;

  assign in_item.func           = in_ch.func;
  assign in_item.swdio_in       = in_ch.swdio_in;
  assign in_item.read_not_write = in_ch.read_not_write;
  assign in_item.ap_not_dp      = in_ch.ap_not_dp;
  assign in_item.reg_addr       = in_ch.reg_addr;
  assign in_item.write_data     = in_ch.write_data;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr.en    = cfg_ch.valid;
  assign cfg_wr.idx   = cfg_ch.reg_index;
  assign cfg_wr.data  = cfg_ch.wr_data;

  swdtm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_item  (in_item),
    .dn_valid (eng_valid),
    .dn_take  (step),
    .dn_item  (eng_item)
  );

  swdtm_engine u_eng (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .step   (step),
    .item   (eng_item),
    .res    (eng_res)
  );

  swdtm_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (eng_valid),
    .up_take  (step),
    .up_item  (eng_res),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_item  (out_item)
  );

  assign out_ch.swclk_pulse = out_item.swclk_pulse;
  assign out_ch.swdio_oe    = out_item.swdio_oe;
  assign out_ch.swdio_out   = out_item.swdio_out;
  assign out_ch.busy_res    = out_item.busy_res;
  assign out_ch.done_res    = out_item.done_res;
  assign out_ch.status      = out_item.status;
  assign out_ch.ack_code    = out_item.ack_code;
  assign out_ch.read_data   = out_item.read_data;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done with busy set");

  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |-> out_ch.done_res)
    else $error("error status without done");

  a_rdata_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.read_data != 32'd0) |-> out_ch.done_res && (out_ch.status == ST_OK))
    else $error("read data outside good completion");

  a_sample_pulsed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.swdio_oe |-> out_ch.swclk_pulse && !out_ch.swdio_out)
    else $error("sampling period without clock");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_ch.valid)
    else $error("result lost");

endmodule

// ===== sv/swdtm_in_stage.sv =====
module swdtm_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  swdtm_pkg::in_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_take,
  output swdtm_pkg::in_item_t dn_item
);
  import swdtm_pkg::*;

  logic     vld_r;
  in_item_t item_r;

  assign up_ready = !vld_r || dn_take;
  assign dn_valid = vld_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

endmodule

// ===== sv/swdtm_engine.sv =====
module swdtm_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swdtm_pkg::cfg_wr_t   cfg_wr,
  input  logic                 step,
  input  swdtm_pkg::in_item_t  item,
  output swdtm_pkg::out_item_t res
);
  import swdtm_pkg::*;

  logic [7:0]  rhl_r, ill_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [31:0] ds_r, ds_nxt;
  logic        par_r, par_nxt;
  logic [3:0]  req_r, req_nxt;
  logic [2:0]  ack_r, ack_nxt;
  logic [2:0]  acc_r, acc_nxt;

  logic        is_start, is_tick;
  logic [7:0]  bc_inc;
  logic [2:0]  acc_new;
  logic        pulse, oe, dout, done;
  logic [1:0]  status;
  logic [31:0] rdata;

  assign is_start = (item.func == FUNC_XFER) || (item.func == FUNC_LRST);
  assign is_tick  = (item.func == FUNC_TICK) && (phase_r != PH_IDLE);
  assign bc_inc   = bc_r + 8'd1;
  assign acc_new  = acc_r | 3'((4'(item.swdio_in) << bc_r[1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rhl_r <= RESET_HIGH_LEN_DEF;
      ill_r <= IDLE_LOW_LEN_DEF;
    end else if (cfg_wr.en) begin
      if (cfg_wr.idx == CFG_RESET_HIGH_LEN) begin
        rhl_r <= cfg_wr.data;
      end else if (cfg_wr.idx == CFG_IDLE_LOW_LEN) begin
        ill_r <= cfg_wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= '0;
      ds_r    <= '0;
      par_r   <= 1'b0;
      req_r   <= '0;
      ack_r   <= '0;
      acc_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      ds_r    <= ds_nxt;
      par_r   <= par_nxt;
      req_r   <= req_nxt;
      ack_r   <= ack_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    ds_nxt    = ds_r;
    par_nxt   = par_r;
    req_nxt   = req_r;
    ack_nxt   = ack_r;
    acc_nxt   = acc_r;
    if (is_start) begin
      if (phase_r == PH_IDLE) begin
        bc_nxt = '0;
        if (item.func == FUNC_XFER) begin
          req_nxt   = {item.reg_addr, item.read_not_write, item.ap_not_dp};
          ds_nxt    = item.read_not_write ? 32'd0 : item.write_data;
          par_nxt   = 1'b0;
          phase_nxt = PH_HDR;
        end else begin
          phase_nxt = (rhl_r == 8'd0) ? PH_LR_SEQ : PH_LR_HI1;
        end
      end
    end else if (is_tick) begin
      unique case (phase_r)
        PH_LR_HI1: begin
          bc_nxt = bc_inc;
          if (bc_inc >= rhl_r) begin
            phase_nxt = PH_LR_SEQ;
            bc_nxt    = '0;
          end
        end
        PH_LR_SEQ: begin
          bc_nxt = bc_inc;
          if (bc_inc >= SEQ_BITS) begin
            bc_nxt = '0;
            if (rhl_r != 8'd0) begin
              phase_nxt = PH_LR_HI2;
            end else begin
              phase_nxt = (ill_r == 8'd0) ? PH_IDLE : PH_LR_LOW;
            end
          end
        end
        PH_LR_HI2: begin
          bc_nxt = bc_inc;
          if (bc_inc >= rhl_r) begin
            bc_nxt    = '0;
            phase_nxt = (ill_r == 8'd0) ? PH_IDLE : PH_LR_LOW;
          end
        end
        PH_LR_LOW: begin
          bc_nxt = bc_inc;
          if (bc_inc >= ill_r) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_HDR: begin
          bc_nxt = bc_inc;
          if (bc_inc >= HDR_BITS) begin
            phase_nxt = PH_TRN_A;
            bc_nxt    = '0;
          end
        end
        PH_TRN_A: begin
          phase_nxt = PH_ACK;
          bc_nxt    = '0;
          acc_nxt   = '0;
        end
        PH_ACK: begin
          acc_nxt = acc_new;
          bc_nxt  = bc_inc;
          if (bc_inc >= ACK_BITS) begin
            ack_nxt = acc_new;
            bc_nxt  = '0;
            if (acc_new == ACK_OK) begin
              par_nxt   = 1'b0;
              phase_nxt = req_r[1] ? PH_RDATA : PH_TRN_W;
            end else begin
              phase_nxt = PH_ACK_TRN;
            end
          end
        end
        PH_ACK_TRN: begin
          if (ack_r == ACK_WAIT) begin
            phase_nxt = PH_HDR;
            bc_nxt    = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_TRN_W: begin
          phase_nxt = PH_WDATA;
          bc_nxt    = '0;
          par_nxt   = 1'b0;
        end
        PH_WDATA: begin
          bc_nxt = bc_inc;
          if (bc_r < DATA_BITS) begin
            par_nxt = par_r ^ ds_r[bc_r[4:0]];
          end else if (bc_r != DATA_BITS) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_RDATA: begin
          if (bc_r < DATA_BITS) begin
            ds_nxt  = ds_r | (32'(item.swdio_in) << bc_r[4:0]);
            par_nxt = par_r ^ item.swdio_in;
            bc_nxt  = bc_inc;
          end else begin
            phase_nxt = (item.swdio_in != par_r) ? PH_IDLE : PH_RTRN;
          end
        end
        PH_RTRN:  phase_nxt = PH_RIDLE;
        PH_RIDLE: phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    pulse  = 1'b0;
    oe     = 1'b1;
    dout   = 1'b0;
    done   = 1'b0;
    status = ST_OK;
    rdata  = '0;
    if (is_tick) begin
      pulse = 1'b1;
      unique case (phase_r)
        PH_LR_HI1: dout = 1'b1;
        PH_LR_SEQ: begin
          dout = SWITCH_SEQ[bc_r[3:0]];
          done = (bc_inc >= SEQ_BITS) && (rhl_r == 8'd0) && (ill_r == 8'd0);
        end
        PH_LR_HI2: begin
          dout = 1'b1;
          done = (bc_inc >= rhl_r) && (ill_r == 8'd0);
        end
        PH_LR_LOW: done = (bc_inc >= ill_r);
        PH_HDR:    dout = hdr_bit(req_r, bc_r[2:0]);
        PH_TRN_A:  oe = 1'b0;
        PH_ACK:    oe = 1'b0;
        PH_ACK_TRN: begin
          oe = 1'b0;
          if (ack_r != ACK_WAIT) begin
            done   = 1'b1;
            status = (ack_r == ACK_FAULT) ? ST_FAULT : ST_INVALID;
          end
        end
        PH_TRN_W:  oe = 1'b0;
        PH_WDATA: begin
          if (bc_r < DATA_BITS) begin
            dout = ds_r[bc_r[4:0]];
          end else if (bc_r == DATA_BITS) begin
            dout = par_r;
          end else begin
            done = 1'b1;
          end
        end
        PH_RDATA: begin
          oe = 1'b0;
          if ((bc_r >= DATA_BITS) && (item.swdio_in != par_r)) begin
            done   = 1'b1;
            status = ST_PARITY;
          end
        end
        PH_RTRN:  oe = 1'b0;
        PH_RIDLE: begin
          done  = 1'b1;
          rdata = ds_r;
        end
        default:  pulse = 1'b0;
      endcase
    end
  end

  assign res.swclk_pulse = pulse;
  assign res.swdio_oe    = oe;
  assign res.swdio_out   = oe & dout;
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.done_res    = done;
  assign res.status      = status;
  assign res.ack_code    = ack_nxt;
  assign res.read_data   = rdata;

endmodule

// ===== sv/swdtm_out_stage.sv =====
module swdtm_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_take,
  input  swdtm_pkg::out_item_t up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output swdtm_pkg::out_item_t dn_item
);
  import swdtm_pkg::*;

  logic      vld_r;
  out_item_t item_r;

  assign up_take  = up_valid && (!vld_r || dn_ready);
  assign dn_valid = vld_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_take) begin
      vld_r <= 1'b1;
    end else if (dn_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      item_r <= up_item;
    end
  end

endmodule
